/* hw/rtl/b64_pkg.sv */
// Shared types, constants and alphabet functions for the Base64 codec.
// No dependencies; imported by every module of the codec.
package b64_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic       MODE_ENC  = 1'b0;
    localparam logic       MODE_DEC  = 1'b1;

    // One group's worth of work handed from front to back
    typedef struct packed {
        logic [23:0] bits;      // group bits, left aligned
        logic        dec;       // 1: emit bytes, 0: emit characters
        logic [1:0]  last_idx;  // index of the final result of this group
        logic [1:0]  npad;      // encode: trailing '=' count
        logic        last;      // group closes the message
        logic        bad;       // decode: flag every result
    } b64_job_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (w < 8'd26)      enc_char = 8'h41 + w;
        else if (w < 8'd52) enc_char = 8'h61 + (w - 8'd26);
        else if (w < 8'd62) enc_char = 8'h30 + (w - 8'd52);
        else if (w == 8'd62) enc_char = 8'h2B;
        else                enc_char = 8'h2F;
    endfunction

    // {invalid, sextet}; invalid characters give sextet zero
    function automatic logic [6:0] dec_sextet(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41;
            dec_sextet = {1'b0, t[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'h61 + 8'd26;
            dec_sextet = {1'b0, t[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30 + 8'd52;
            dec_sextet = {1'b0, t[5:0]};
        end else if (c == 8'h2B) begin
            dec_sextet = {1'b0, 6'd62};
        end else if (c == 8'h2F) begin
            dec_sextet = {1'b0, 6'd63};
        end else begin
            dec_sextet = {1'b1, 6'd0};
        end
    endfunction

endpackage

/* hw/rtl/b64_front.sv */
// Front end: holds the mode register, packs items into groups and
// issues one job per completed group or at the end of a message. Depends on b64_pkg.
module b64_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mode_we,
    input  logic                mode_wdata,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                in_last,
    output logic                push,
    output b64_pkg::b64_job_t   job
);
    import b64_pkg::*;

    logic        mode_reg;
    logic [23:0] bits_reg, bits_next;
    logic [1:0]  count_reg, count_next;
    logic [1:0]  pad_reg, pad_next;
    logic        err_reg, err_next;

    logic        emit;
    logic [1:0]  cnt_eff;
    logic [23:0] bits_eff, enc_bits, dec_bits, triple;
    logic [6:0]  sx;
    logic        is_pad, err_new;
    logic [5:0]  v;
    logic [1:0]  pad_new;

    always_comb
    begin
        cnt_eff  = (count_reg > 2'd2) ? 2'd0 : count_reg;
        bits_eff = (count_reg > 2'd2) ? 24'd0 : bits_reg;
        enc_bits = {bits_eff[15:0], data_byte};

        is_pad  = (data_byte == PAD_CHAR);
        sx      = dec_sextet(data_byte);
        v       = is_pad ? 6'd0 : sx[5:0];
        err_new = err_reg | (!is_pad & sx[6]);
        pad_new = pad_reg | {is_pad && count_reg == 2'd2, is_pad && count_reg == 2'd3};
        dec_bits = {bits_reg[17:0], v};

        job        = '0;
        job.last   = in_last;
        triple     = 24'd0;
        if (mode_reg == MODE_ENC) begin
            emit = (cnt_eff == 2'd2) || in_last;
            case (cnt_eff)
                2'd0:    triple = {enc_bits[7:0], 16'd0};
                2'd1:    triple = {enc_bits[15:0], 8'd0};
                default: triple = enc_bits;
            endcase
            job.dec      = 1'b0;
            job.last_idx = 2'd3;
            job.npad     = (cnt_eff == 2'd0) ? 2'd2 : ((cnt_eff == 2'd1) ? 2'd1 : 2'd0);
            job.bad      = 1'b0;
        end else begin
            emit = (count_reg == 2'd3) || in_last;
            case (count_reg)
                2'd0:    triple = {dec_bits[5:0], 18'd0};
                2'd1:    triple = {dec_bits[11:0], 12'd0};
                2'd2:    triple = {dec_bits[17:0], 6'd0};
                default: triple = dec_bits;
            endcase
            job.dec = 1'b1;
            job.bad = err_new | (count_reg != 2'd3);
            // short final group keeps all three bytes
            if (count_reg == 2'd3 && in_last)
                job.last_idx = 2'd2 - {1'b0, pad_new[0]} - {1'b0, pad_new[1]};
            else
                job.last_idx = 2'd2;
        end
        job.bits = triple;
        push     = accept && emit;

        bits_next  = bits_reg;
        count_next = count_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        if (accept) begin
            if (emit && in_last) begin
                bits_next  = 24'd0;
                count_next = 2'd0;
                pad_next   = 2'd0;
                err_next   = 1'b0;
            end else if (emit) begin
                bits_next  = 24'd0;
                count_next = 2'd0;
                pad_next   = 2'd0;
                err_next   = (mode_reg == MODE_DEC) ? err_new : err_reg;
            end else if (mode_reg == MODE_ENC) begin
                bits_next  = enc_bits;
                count_next = cnt_eff + 2'd1;
            end else begin
                bits_next  = dec_bits;
                count_next = count_reg + 2'd1;
                pad_next   = pad_new;
                err_next   = err_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_ENC;
            bits_reg  <= 24'd0;
            count_reg <= 2'd0;
            pad_reg   <= 2'd0;
            err_reg   <= 1'b0;
        end else if (mode_we) begin
            mode_reg  <= mode_wdata;
            bits_reg  <= 24'd0;
            count_reg <= 2'd0;
            pad_reg   <= 2'd0;
            err_reg   <= 1'b0;
        end else begin
            bits_reg  <= bits_next;
            count_reg <= count_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* hw/rtl/b64_queue.sv */
// Small job queue in flip-flops between front and back.
// Depends on b64_pkg.
module b64_queue #(
    parameter int unsigned DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64_pkg::b64_job_t   push_job,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output b64_pkg::b64_job_t   pop_job
);
    import b64_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64_job_t      slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

endmodule

/* hw/rtl/b64_back.sv */
// Back end: expands one job into its result items through a registered output stage,
// one per cycle unless out_ready stalls that stage. Depends on b64_pkg.
module b64_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  b64_pkg::b64_job_t   q_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                bad_input
);
    import b64_pkg::*;

    b64_job_t   job_reg, job_next;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic       ol_reg, ol_next;
    logic       obad_reg, obad_next;

    logic       take, emit, done, pad_here;
    logic [2:0] pad_sum;
    logic [7:0] res;

    always_comb
    begin
        take    = !ov_reg || out_ready;
        emit    = busy_reg && take;
        done    = emit && (idx_reg == job_reg.last_idx);
        pop     = q_valid && (!busy_reg || done);

        pad_sum  = {1'b0, idx_reg} + {1'b0, job_reg.npad};
        pad_here = pad_sum[2];
        if (job_reg.dec)
            res = job_reg.bits[23:16];
        else if (pad_here)
            res = PAD_CHAR;
        else
            res = enc_char(job_reg.bits[23:18]);

        job_next  = job_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop) begin
            job_next  = q_job;
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end else if (emit) begin
            idx_next = idx_reg + 2'd1;
            job_next.bits = job_reg.dec ? {job_reg.bits[15:0], 8'd0}
                                        : {job_reg.bits[17:0], 6'd0};
            if (done)
                busy_next = 1'b0;
        end

        ov_next   = ov_reg;
        ob_next   = ob_reg;
        ol_next   = ol_reg;
        obad_next = obad_reg;
        if (emit) begin
            ov_next   = 1'b1;
            ob_next   = res;
            ol_next   = job_reg.last && (idx_reg == job_reg.last_idx);
            obad_next = job_reg.bad;
        end else if (out_ready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        ob_reg   <= ob_next;
        ol_reg   <= ol_next;
        obad_reg <= obad_next;
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;
    assign bad_input = obad_reg;

    a_fill_output: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !ov_reg |=> ov_reg)
        else $error("busy back end left output empty");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= job_reg.last_idx)
        else $error("result index past end of group");

    a_pad_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !job_reg.dec && job_reg.npad != 2'd0 |-> job_reg.last)
        else $error("padded group not at end of message");

endmodule

/* hw/rtl/base64_codec_top.sv */
// Path: a group's results pass through the job queue, the back end's job register and its output register.
// Throughput: one result per cycle while out_ready is high; encode input is bounded by the
// single output register of the back end; decode takes one character per cycle.
// Input items stall only when the job queue is full.
// Reset: mode returns to encode, group state, queue and output stage are cleared.
// Top level of the Base64 codec; uses b64_pkg, b64_front, b64_queue, b64_back.
module base64_codec_top #(
    parameter int unsigned QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode_we,
    input  logic       mode_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       bad_input
);
    import b64_pkg::*;

    b64_job_t push_job, pop_job;
    logic     push, pop, q_full, q_valid;

    assign in_ready = !q_full;

    b64_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .accept     (in_valid && in_ready),
        .data_byte  (data_byte),
        .in_last    (in_last),
        .push       (push),
        .job        (push_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_job   (pop_job)
    );

    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .bad_input (bad_input)
    );

endmodule

/* tb/base64_codec_checker.sv */
`timescale 1ns / 1ps
// Checker for the Base64 codec: watches the config port and both item channels,
// predicts every result from the accepted input items and compares them in order.
// Depends on b64_pkg for the mode codes and the pad character.
module base64_codec_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode_we,
    input  logic       mode_wdata,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       out_last,
    input  logic       bad_input,
    output int         error_count,
    output int         expected_left
);
    import b64_pkg::*;

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] value;
        logic       fin;
        logic       bad;
    } codec_result_t;

    codec_result_t expected_q[$];
    int            fails;

    logic          mode_r;
    logic [23:0]   grp_bits;
    logic [1:0]    grp_cnt;
    logic [1:0]    pad_flags;     // bit1: '=' in third slot, bit0: '=' in fourth slot
    logic          err_flag;

    function automatic logic [7:0] char_of(input logic [5:0] idx);
        return ALPHABET[8*(63-idx) +: 8];
    endfunction

    // {invalid, sextet}
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (char_of(6'(i)) == c)
                return {1'b0, 6'(i)};
        end
        return {1'b1, 6'd0};
    endfunction

    task automatic clear_group();
        grp_bits  = '0;
        grp_cnt   = '0;
        pad_flags = '0;
        err_flag  = 1'b0;
    endtask

    task automatic push_result(input logic [7:0] v, input logic f, input logic b);
        codec_result_t r;
        r.value = v;
        r.fin   = f;
        r.bad   = b;
        expected_q.push_back(r);
    endtask

    task automatic predict_encode(input logic [7:0] b, input logic l);
        int          n;
        int          npad;
        logic [23:0] triple;
        logic [7:0]  ch;
        if (grp_cnt > 2'd2)
        begin
            grp_bits = '0;
            grp_cnt  = '0;
        end
        grp_bits = {grp_bits[15:0], b};
        grp_cnt  = grp_cnt + 2'd1;
        n = grp_cnt;
        if (n < 3 && !l)
            return;
        triple = grp_bits << (8 * (3 - n));
        npad   = (n == 1) ? 2 : (n == 2) ? 1 : 0;
        for (int k = 0; k < 4; k++)
        begin
            ch = char_of(triple[18-6*k +: 6]);
            if (k >= 4 - npad)
                ch = PAD_CHAR;
            push_result(ch, l && (k == 3), 1'b0);
        end
        if (l)
            clear_group();
        else
        begin
            grp_bits = '0;
            grp_cnt  = '0;
        end
    endtask

    task automatic predict_decode(input logic [7:0] c, input logic l);
        int          pos;
        int          n;
        int          cnt;
        logic [5:0]  v;
        logic [6:0]  lk;
        logic [23:0] triple;
        logic        bad;
        pos = grp_cnt;
        if (c == PAD_CHAR)
        begin
            v = '0;
            if (pos == 2) pad_flags[1] = 1'b1;
            if (pos == 3) pad_flags[0] = 1'b1;
        end
        else
        begin
            lk = sextet_lookup(c);
            v  = lk[5:0];
            if (lk[6])
                err_flag = 1'b1;
        end
        grp_bits = {grp_bits[17:0], v};
        n = pos + 1;
        if (n < 4 && !l)
        begin
            grp_cnt = 2'(n);
            return;
        end
        triple = grp_bits << (6 * (4 - n));
        bad = err_flag;
        cnt = 3;
        // short final group: all three bytes, flagged, pads drop nothing
        if (n < 4)
            bad = 1'b1;
        else if (l)
            cnt = 3 - int'(pad_flags[0]) - int'(pad_flags[1]);
        for (int k = 0; k < cnt; k++)
            push_result(triple[16-8*k +: 8], l && (k == cnt - 1), bad);
        if (l)
            clear_group();
        else
        begin
            grp_bits  = '0;
            grp_cnt   = '0;
            pad_flags = '0;
        end
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        fails++;
        $display("MISMATCH %s: got 0x%02h, expected 0x%02h at %0t",
                 what, got, want, $time);
    endtask

    task automatic check_result();
        codec_result_t want;
        if (expected_q.size() == 0)
        begin
            report("result with none expected", out_byte, 8'h00);
            return;
        end
        want = expected_q.pop_front();
        if (out_byte !== want.value)
            report("out_byte", out_byte, want.value);
        if (out_last !== want.fin)
            report("out_last", {7'd0, out_last}, {7'd0, want.fin});
        if (bad_input !== want.bad)
            report("bad_input", {7'd0, bad_input}, {7'd0, want.bad});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            mode_r = MODE_ENC;
            clear_group();
            fails = 0;
            error_count   <= 0;
            expected_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (mode_we)
            begin
                mode_r = mode_wdata;
                clear_group();
            end
            if (in_valid && in_ready)
            begin
                if (mode_r == MODE_ENC)
                    predict_encode(data_byte, in_last);
                else
                    predict_decode(data_byte, in_last);
            end
            error_count   <= fails;
            expected_left <= expected_q.size();
        end
    end

endmodule

/* tb/base64_codec_top_tb.sv */
`timescale 1ns / 1ps
// Top of the Base64 codec testbench: clock, reset, stimulus and verdict.
// Depends on b64_pkg, base64_codec_top and base64_codec_checker.
module base64_codec_top_tb;
    import b64_pkg::*;

    localparam int ITEM_TARGET  = 430;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;

    logic       clk;
    logic       rst_n;
    logic       mode_we;
    logic       mode_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_input;

    int         error_count;
    int         expected_left;
    int         items_sent;
    bit         tx_idle_en;
    bit         rx_idle_en;
    int         rx_hold;
    logic [7:0] msg_q[$];

    base64_codec_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .bad_input  (bad_input)
    );

    base64_codec_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode_we       (mode_we),
        .mode_wdata    (mode_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .in_last       (in_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .bad_input     (bad_input),
        .error_count   (error_count),
        .expected_left (expected_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stall per item when enabled, plus one long hold when requested
    initial
    begin : receiver
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_idle_en ? $urandom_range(0, 16) : 0;
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic drive_item(input logic [7:0] b, input logic l);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        in_last   <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0) @(posedge clk);
    endtask

    // mode writes only once every expected result has left the codec
    task automatic set_mode(input logic m);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mode_we    <= 1'b1;
        mode_wdata <= m;
        @(posedge clk);
        mode_we    <= 1'b0;
    endtask

    task automatic send_queue(input bit end_msg);
        for (int i = 0; i < msg_q.size(); i++)
        begin
            drive_item(msg_q[i], end_msg && (i == msg_q.size() - 1));
            if (tx_idle_en && $urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    task automatic build_encode_msg(input int len);
        msg_q.delete();
        repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // mostly well-formed text, some truncated, corrupted or pure noise
    task automatic build_decode_msg();
        int kind;
        int ngrp;
        int npad;
        msg_q.delete();
        kind = $urandom_range(0, 9);
        ngrp = $urandom_range(1, 4);
        repeat (4 * ngrp) msg_q.push_back(enc_char(6'($urandom_range(0, 63))));
        if (kind < 7)
        begin
            npad = $urandom_range(0, 2);
            for (int i = 0; i < npad; i++)
                msg_q[msg_q.size() - 1 - i] = PAD_CHAR;
        end
        else if (kind == 7)
        begin
            repeat ($urandom_range(1, 3)) msg_q.delete(msg_q.size() - 1);
        end
        else if (kind == 8)
        begin
            msg_q[$urandom_range(0, msg_q.size() - 1)] = PAD_CHAR;
            msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else
        begin
            msg_q.delete();
            repeat ($urandom_range(1, 9)) msg_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        int   phase_items;
        logic phase_mode;
        rst_n      = 1'b0;
        mode_we    = 1'b0;
        mode_wdata = MODE_ENC;
        in_valid   = 1'b0;
        data_byte  = 8'h00;
        in_last    = 1'b0;
        items_sent = 0;
        rx_hold    = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encode: two pads, one pad, full group; extreme byte values
        set_mode(MODE_ENC);
        msg_q = '{8'h00};
        send_queue(1);
        msg_q = '{8'hFF, 8'h80};
        send_queue(1);
        msg_q = '{8'hFF, 8'hFE, 8'h01};
        send_queue(1);

        // decode: partial group dropped by a mode write
        set_mode(MODE_DEC);
        msg_q = '{"Q", "Q"};
        send_queue(0);
        set_mode(MODE_DEC);
        // pad inside the message, then pad in third slot only of the last group
        msg_q = '{"Q", "Q", "=", "=", "T", "m", "=", "x"};
        send_queue(1);
        // non-alphabet characters
        msg_q = '{"A", 8'hFF, "=", 8'h00};
        send_queue(1);
        // length not a multiple of four
        msg_q = '{"Q", "U"};
        send_queue(1);

        // output held off while input keeps coming, so the job queue fills
        set_mode(MODE_ENC);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold    = HOLD_CYCLES;
        build_encode_msg(36);
        send_queue(1);

        for (int phase = 0; items_sent < ITEM_TARGET; phase++)
        begin
            phase_mode = (phase % 2 == 0) ? MODE_DEC : MODE_ENC;
            set_mode(phase_mode);
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_idle_en  = ($urandom_range(0, 3) != 0);
            phase_items = 0;
            while (phase_items < 50 && items_sent < ITEM_TARGET)
            begin
                if (phase_mode == MODE_ENC)
                    build_encode_msg($urandom_range(1, 10));
                else
                    build_decode_msg();
                phase_items += msg_q.size();
                send_queue(1);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
